/* hw/rtl/grcw_pkg.sv */
// ----------------------------------------------------------------------------
// grcw_pkg
// Shared types and constants for the 2D grid ray cell walker.
// ----------------------------------------------------------------------------
package grcw_pkg;

    localparam int MAX_RUN = 64;
    localparam int LIM_W   = $clog2(MAX_RUN + 1);

    typedef logic [31:0]      t_dist;
    typedef logic [LIM_W-1:0] t_lim;

    localparam t_dist DIST_SAT = 32'hFFFF_FFFF;
    localparam t_lim  LIM_RST  = t_lim'(MAX_RUN);

endpackage

/* hw/rtl/grid_ray_cell_walker_core.sv */
// ----------------------------------------------------------------------------
// grid_ray_cell_walker_core
// Amanatides-Woo 2D grid traversal of one ray, bit-serial setup.
// ----------------------------------------------------------------------------
// One request is one ray. Setup squares the direction components, then runs
// a restoring divider (one quotient bit a cycle) and a square-root unit (one
// root bit a cycle) for both axes side by side, then one multiply for the
// first boundary distances. After that the walker emits one cell a cycle
// while the output is not stalled, up to cell_limit cells. The next request
// is taken once the last cell of the current ray is in the output register.
module grid_ray_cell_walker_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  grcw_pkg::t_lim        i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [31:0]    i_start_x,
    input  logic signed [31:0]    i_start_y,
    input  logic signed [15:0]    i_dir_x,
    input  logic signed [15:0]    i_dir_y,
    input  grcw_pkg::t_dist       i_ray_length,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [15:0]    o_cell_x,
    output logic signed [15:0]    o_cell_y,
    output grcw_pkg::t_dist       o_entry_distance,
    output logic                  o_last,
    output logic                  o_truncated
);
    import grcw_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_WALK = 3'd6;

    logic [2:0]         r_state;
    logic [5:0]         r_cnt;
    t_lim               r_cfg_lim;
    t_lim               r_lim;
    t_lim               r_n;
    logic signed [15:0] r_dir [2];
    logic [15:0]        r_frac [2];
    logic [15:0]        r_cell [2];
    logic [31:0]        r_asq [2];
    logic [31:0]        r_sum;
    logic [63:0]        r_dvd [2];
    logic [31:0]        r_rem [2];
    logic [31:0]        r_root [2];
    logic [33:0]        r_srem [2];
    t_dist              r_step [2];
    t_dist              r_tn [2];
    t_dist              r_t;
    t_dist              r_len;

    logic               r_ovalid;
    logic [15:0]        r_ocx;
    logic [15:0]        r_ocy;
    t_dist              r_odist;
    logic               r_olast;
    logic               r_otrunc;

    logic [15:0]        w_mag [2];
    logic [32:0]        w_dtrial [2];
    logic               w_dge [2];
    logic [31:0]        n_rem [2];
    logic [35:0]        w_strial [2];
    logic [35:0]        w_sref [2];
    logic               w_sge [2];
    logic [33:0]        n_srem [2];
    logic [16:0]        w_bound [2];
    logic [48:0]        w_prod [2];
    t_dist              w_tfirst [2];
    logic [32:0]        w_tsum [2];
    t_dist              n_tn [2];
    t_lim               w_cfg_clamp;

    logic               w_take_y;
    t_dist              w_cand;
    logic               w_within;
    t_lim               w_n1;
    logic               w_at_lim;
    logic               w_end;
    logic               w_slot;
    logic               w_accept;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_mag[k]    = r_dir[k][15] ? 16'(-r_dir[k]) : 16'(r_dir[k]);
            w_dtrial[k] = {r_rem[k], r_dvd[k][63]};
            w_dge[k]    = w_dtrial[k] >= {1'b0, r_asq[k]};
            n_rem[k]    = w_dge[k] ? 32'(w_dtrial[k] - {1'b0, r_asq[k]})
                                   : w_dtrial[k][31:0];
            w_strial[k] = {r_srem[k], r_dvd[k][63:62]};
            w_sref[k]   = {2'b00, r_root[k], 2'b01};
            w_sge[k]    = w_strial[k] >= w_sref[k];
            n_srem[k]   = w_sge[k] ? 34'(w_strial[k] - w_sref[k]) : w_strial[k][33:0];
            w_bound[k]  = r_dir[k][15] ? {1'b0, r_frac[k]}
                                       : 17'h10000 - {1'b0, r_frac[k]};
            w_prod[k]   = 49'(w_bound[k]) * 49'(r_root[k]);
            w_tfirst[k] = w_prod[k][48] ? DIST_SAT : w_prod[k][47:16];
            w_tsum[k]   = {1'b0, r_tn[k]} + {1'b0, r_step[k]};
            n_tn[k]     = w_tsum[k][32] ? DIST_SAT : w_tsum[k][31:0];
        end
        if (r_cfg_lim == '0) begin
            w_cfg_clamp = t_lim'(1);
        end else if (r_cfg_lim > LIM_RST) begin
            w_cfg_clamp = LIM_RST;
        end else begin
            w_cfg_clamp = r_cfg_lim;
        end
        w_take_y = r_tn[1] <= r_tn[0];
        w_cand   = w_take_y ? r_tn[1] : r_tn[0];
        w_within = (w_cand != DIST_SAT) && (w_cand <= r_len);
        w_n1     = r_n + t_lim'(1);
        w_at_lim = w_n1 >= r_lim;
        w_end    = !w_within || w_at_lim;
        w_slot   = !r_ovalid || !i_stall;
        w_accept = i_valid && (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg_lim <= LIM_RST;
            r_ovalid  <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_lim <= i_cfg_wdata;
            end
            if (r_state == ST_WALK && w_slot) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_WALK;
                end
                ST_WALK: begin
                    if (w_slot && w_end) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_dir[0]  <= i_dir_x;
                r_dir[1]  <= i_dir_y;
                r_frac[0] <= i_start_x[15:0];
                r_frac[1] <= i_start_y[15:0];
                r_cell[0] <= i_start_x[31:16];
                r_cell[1] <= i_start_y[31:16];
                r_len     <= i_ray_length;
                r_lim     <= w_cfg_clamp;
            end
            ST_SQ: begin
                for (int k = 0; k < 2; k++) begin
                    r_asq[k] <= 32'(w_mag[k]) * 32'(w_mag[k]);
                end
            end
            ST_SUM: begin
                r_sum <= r_asq[0] + r_asq[1];
                for (int k = 0; k < 2; k++) begin
                    r_dvd[k] <= {r_asq[0] + r_asq[1], 32'h0};
                    r_rem[k] <= '0;
                end
            end
            ST_DIV: begin
                for (int k = 0; k < 2; k++) begin
                    r_rem[k] <= n_rem[k];
                    r_dvd[k] <= {r_dvd[k][62:0], w_dge[k]};
                    r_root[k] <= '0;
                    r_srem[k] <= '0;
                end
            end
            ST_SQRT: begin
                for (int k = 0; k < 2; k++) begin
                    r_srem[k] <= n_srem[k];
                    r_root[k] <= {r_root[k][30:0], w_sge[k]};
                    r_dvd[k]  <= {r_dvd[k][61:0], 2'b00};
                end
            end
            ST_MUL: begin
                r_t <= '0;
                r_n <= '0;
                for (int k = 0; k < 2; k++) begin
                    if (r_dir[k] == 16'sd0 || r_sum == '0) begin
                        r_step[k] <= DIST_SAT;
                        r_tn[k]   <= DIST_SAT;
                    end else begin
                        r_step[k] <= r_root[k];
                        r_tn[k]   <= w_tfirst[k];
                    end
                end
            end
            ST_WALK: begin
                if (w_slot) begin
                    r_ocx    <= r_cell[0];
                    r_ocy    <= r_cell[1];
                    r_odist  <= r_t;
                    r_olast  <= w_end;
                    r_otrunc <= w_within && w_at_lim;
                    r_n      <= w_n1;
                    if (!w_end) begin
                        r_t <= w_cand;
                        if (w_take_y) begin
                            r_cell[1] <= r_dir[1][15] ? r_cell[1] - 16'd1 : r_cell[1] + 16'd1;
                            r_tn[1]   <= n_tn[1];
                        end else begin
                            r_cell[0] <= r_dir[0][15] ? r_cell[0] - 16'd1 : r_cell[0] + 16'd1;
                            r_tn[0]   <= n_tn[0];
                        end
                    end
                end
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    assign o_stall          = r_state != ST_IDLE;
    assign o_valid          = r_ovalid;
    assign o_cell_x         = r_ocx;
    assign o_cell_y         = r_ocy;
    assign o_entry_distance = r_odist;
    assign o_last           = r_olast;
    assign o_truncated      = r_otrunc;

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_truncated |-> o_last)
        else $error("truncated flag without last");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WALK |-> r_n < r_lim)
        else $error("cell count beyond limit");

    a_dist_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=>
            !o_valid || o_entry_distance >= $past(o_entry_distance))
        else $error("entry distance went backward");

endmodule

/* bench/tb_grid_ray_cell_walker_core.sv */
// ----------------------------------------------------------------------------
// tb_grid_ray_cell_walker_core
// Self-checking bench for the 2D grid ray cell walker. Rays are queued by a
// stimulus block, driven with random idle bursts, and every emitted cell is
// compared against a fixed-point traversal predictor kept in this file.
// ----------------------------------------------------------------------------
module tb_grid_ray_cell_walker_core;

    import grcw_pkg::*;

    typedef struct {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        t_dist              ray_length;
    } t_ray;

    typedef struct {
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        t_dist              entry_distance;
        logic               last;
        logic               truncated;
    } t_cell;

    localparam longint CYCLE_LIMIT = 2_000_000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    t_lim               i_cfg_wdata;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_start_x;
    logic signed [31:0] i_start_y;
    logic signed [15:0] i_dir_x;
    logic signed [15:0] i_dir_y;
    t_dist              i_ray_length;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_cell_x;
    logic signed [15:0] o_cell_y;
    t_dist              o_entry_distance;
    logic               o_last;
    logic               o_truncated;

    t_ray   pending_rays[$];
    t_cell  expected_cells[$];
    t_lim   model_cell_limit;
    int     error_count;
    int     rays_sent;
    int     cells_seen;
    int     truncations_seen;
    bit     quiet_phase;
    int     send_idle;
    int     recv_idle;
    longint cycle_count;

    // stall as sampled at the last rising edge, so the driver sees the handshake
    logic   o_stall_q;

    grid_ray_cell_walker_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_start_x        (i_start_x),
        .i_start_y        (i_start_y),
        .i_dir_x          (i_dir_x),
        .i_dir_y          (i_dir_y),
        .i_ray_length     (i_ray_length),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_cell_x         (o_cell_x),
        .o_cell_y         (o_cell_y),
        .o_entry_distance (o_entry_distance),
        .o_last           (o_last),
        .o_truncated      (o_truncated)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned sat_dist(longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    task automatic axis_prepare(input longint signed d, input longint unsigned sum_sq,
                                input logic [31:0] start, output longint unsigned step,
                                output longint unsigned tnext, output int dstep);
        longint unsigned mag;
        longint unsigned frac;
        longint unsigned bound;
        if (d == 0) begin
            step = 64'hFFFF_FFFF;
            tnext = 64'hFFFF_FFFF;
            dstep = 0;
        end else begin
            mag = (d < 0) ? -d : d;
            step = sat_dist(int_sqrt((sum_sq << 32) / (mag * mag)));
            frac = start[15:0];
            bound = (d > 0) ? 65536 - frac : frac;
            tnext = sat_dist((bound * step) >> 16);
            dstep = (d > 0) ? 1 : -1;
        end
    endtask

    task automatic predict_ray_cells(input t_ray r);
        longint signed   dx;
        longint signed   dy;
        longint unsigned sum_sq;
        longint unsigned step_x;
        longint unsigned step_y;
        longint unsigned tx;
        longint unsigned ty;
        longint unsigned walk_dist;
        longint unsigned cand;
        longint unsigned limit;
        int              sx;
        int              sy;
        int              count;
        bit              take_y;
        t_cell           c;
        dx = r.dir_x;
        dy = r.dir_y;
        sum_sq = dx * dx + dy * dy;
        axis_prepare(dx, sum_sq, r.start_x, step_x, tx, sx);
        axis_prepare(dy, sum_sq, r.start_y, step_y, ty, sy);
        c.cell_x = r.start_x[31:16];
        c.cell_y = r.start_y[31:16];
        walk_dist = 0;
        limit = model_cell_limit;
        if (limit < 1) limit = 1;
        if (limit > MAX_RUN) limit = MAX_RUN;
        count = 0;
        forever begin
            c.entry_distance = walk_dist[31:0];
            c.last = 1'b0;
            c.truncated = 1'b0;
            count++;
            take_y = (ty <= tx);
            cand = take_y ? ty : tx;
            if (cand == 64'hFFFF_FFFF || cand > r.ray_length) begin
                c.last = 1'b1;
                expected_cells.push_back(c);
                break;
            end
            if (count >= limit) begin
                c.last = 1'b1;
                c.truncated = 1'b1;
                expected_cells.push_back(c);
                break;
            end
            expected_cells.push_back(c);
            walk_dist = cand;
            if (take_y) begin
                c.cell_y = c.cell_y + 16'(sy);
                ty = sat_dist(ty + step_y);
            end else begin
                c.cell_x = c.cell_x + 16'(sx);
                tx = sat_dist(tx + step_x);
            end
        end
    endtask

    task automatic queue_ray(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [15:0] dx, input logic [15:0] dy,
                             input logic [31:0] len);
        t_ray r;
        r.start_x = sx;
        r.start_y = sy;
        r.dir_x = dx;
        r.dir_y = dy;
        r.ray_length = len;
        pending_rays.push_back(r);
    endtask

    task automatic drain_and_settle();
        while (pending_rays.size() != 0 || i_valid || expected_cells.size() != 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_cell_limit(input t_lim v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        model_cell_limit = v;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return {16'($signed($urandom_range(0, 40)) - 20), 16'($urandom())};
            2: return {16'($urandom()), 16'h0000};
            default: return {16'($urandom()), 16'($urandom())};
        endcase
    endfunction

    function automatic logic [15:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'($signed($urandom_range(0, 16)) - 8);
            2: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] rand_length();
        case ($urandom_range(0, 4))
            0: return 32'($urandom_range(0, 3)) << 16;
            1: return $urandom_range(0, 32'h0020_0000);
            2: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'hFFFF_FFFE;
            3: return $urandom();
            default: return $urandom_range(0, 32'h0010_0000) << 4;
        endcase
    endfunction

    // driver: present requests at the falling edge, hold while stalled, and drive random output stalls
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall_q) begin
                if (pending_rays.size() != 0) void'(pending_rays.pop_front());
            end
            if (!i_valid || !o_stall_q) begin
                if (send_idle > 0) begin
                    send_idle <= send_idle - 1;
                    i_valid <= 1'b0;
                end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                    send_idle <= $urandom_range(0, 3);
                    i_valid <= 1'b0;
                end else if (pending_rays.size() > 0) begin
                    i_valid <= 1'b1;
                    i_start_x <= pending_rays[0].start_x;
                    i_start_y <= pending_rays[0].start_y;
                    i_dir_x <= pending_rays[0].dir_x;
                    i_dir_y <= pending_rays[0].dir_y;
                    i_ray_length <= pending_rays[0].ray_length;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (recv_idle > 0) begin
                recv_idle <= recv_idle - 1;
                i_stall <= 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                recv_idle <= $urandom_range(0, 3);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        o_stall_q <= o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            predict_ray_cells('{i_start_x, i_start_y, i_dir_x, i_dir_y, i_ray_length});
            rays_sent++;
        end
    end

    // monitor: check each accepted cell against the oldest expectation
    always @(posedge i_clk) begin
        t_cell e;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            cells_seen++;
            if (o_truncated) truncations_seen++;
            if (expected_cells.size() == 0) begin
                $display("%0t: unexpected cell expected none actual x=%0d y=%0d d=%h",
                         $time, o_cell_x, o_cell_y, o_entry_distance);
                error_count++;
            end else begin
                e = expected_cells.pop_front();
                if (o_cell_x !== e.cell_x || o_cell_y !== e.cell_y
                    || o_entry_distance !== e.entry_distance || o_last !== e.last
                    || o_truncated !== e.truncated) begin
                    $display("%0t: cell mismatch expected x=%0d y=%0d d=%h l=%b t=%b",
                             $time, e.cell_x, e.cell_y, e.entry_distance, e.last,
                             e.truncated);
                    $display("%0t:               actual   x=%0d y=%0d d=%h l=%b t=%b",
                             $time, o_cell_x, o_cell_y, o_entry_distance, o_last,
                             o_truncated);
                    error_count++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int i;
        error_count = 0;
        rays_sent = 0;
        cells_seen = 0;
        truncations_seen = 0;
        quiet_phase = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        cycle_count = 0;
        model_cell_limit = LIM_RST;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_start_x = '0;
        i_start_y = '0;
        i_dir_x = '0;
        i_dir_y = '0;
        i_ray_length = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rays under the reset limit
        queue_ray(32'h0001_8000, 32'h0002_4000, 16'd3, 16'd2, 32'h0008_0000);
        queue_ray(32'h0000_0000, 32'h0000_0000, 16'd0, 16'd0, 32'hFFFF_FFFF);
        queue_ray(32'h0000_0000, 32'h0000_0000, 16'd1, 16'd0, 32'hFFFF_FFFF);
        queue_ray(32'h0003_0000, 32'h0003_0000, -16'sd1, -16'sd1, 32'h0000_0000);
        queue_ray(32'h0000_8000, 32'h0000_8000, 16'd1, 16'd1, 32'h0004_0000);
        queue_ray(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h8000, 32'h0010_0000);
        queue_ray(32'h8000_0000, 32'h7FFF_0000, 16'h8000, 16'h0000, 32'h0005_0000);
        queue_ray(32'hFFFF_4000, 32'h0000_C000, 16'd0, -16'sd5, 32'hFFFF_FFFE);
        queue_ray(32'h0000_0001, 32'hFFFF_FFFF, 16'd1, 16'h7FFF, 32'h0100_0000);
        queue_ray(32'hABCD_1234, 32'h5432_EDCB, 16'h5555, 16'hAAAA, 32'h0003_0000);
        queue_ray(32'h0000_0000, 32'h0000_0000, 16'd1, 16'd1, 32'hFFFF_FFFF);
        drain_and_settle();

        write_cell_limit(t_lim'(1));
        queue_ray(32'h0000_8000, 32'h0000_8000, 16'd1, 16'd1, 32'h0004_0000);
        queue_ray(32'h0000_8000, 32'h0000_8000, 16'd0, 16'd0, 32'h0004_0000);
        drain_and_settle();
        write_cell_limit(t_lim'(0));
        queue_ray(32'h0000_8000, 32'h0000_8000, 16'd1, 16'd1, 32'h0004_0000);
        drain_and_settle();
        write_cell_limit(t_lim'(127));
        queue_ray(32'h0000_0000, 32'h0000_0000, 16'd7, 16'd3, 32'hFFFF_FFFF);
        queue_ray(32'h0000_0000, 32'h0000_0000, -16'sd7, 16'd3, 32'h0080_0000);
        drain_and_settle();
        write_cell_limit(t_lim'(65));
        queue_ray(32'h0000_0000, 32'h0000_0000, 16'd2, -16'sd9, 32'hFFFF_FFFF);
        drain_and_settle();

        // random rays under several limits
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_cell_limit(t_lim'(4));
                1: write_cell_limit(t_lim'(64));
                2: write_cell_limit(t_lim'($urandom_range(1, 20)));
                3: write_cell_limit(t_lim'($urandom_range(0, 127)));
                4: write_cell_limit(t_lim'(16));
                default: begin
                    write_cell_limit(t_lim'(8));
                    quiet_phase = 1'b1;
                end
            endcase
            for (i = 0; i < 18; i++)
                queue_ray(rand_coord(), rand_coord(), rand_dir(), rand_dir(),
                          rand_length());
            drain_and_settle();
        end

        $display("rays sent: %0d, cells checked: %0d, truncated runs: %0d",
                 rays_sent, cells_seen, truncations_seen);
        $display("covered limit extremes, zero and saturated directions, wrap");
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/grcw_pkg.sv
hw/rtl/grid_ray_cell_walker_core.sv
bench/tb_grid_ray_cell_walker_core.sv
